// ===== design/ftrt_pkg.sv =====
// Shared types, constants and the FLV header table for the tag range trimmer.
package ftrt_pkg;

    localparam int REG_W = 40;
    localparam int HEAD_LEN = 13;
    localparam int HEAD_IDX_W = 4;
    localparam int TAG_OVERHEAD = 15;
    localparam int TAG_HDR_LAST = 10;
    localparam int FILE_HDR_LAST = 12;
    localparam int FIRST_TAG_OFFSET = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_END = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       head;
        logic       stream_end;
    } op_t;

    function automatic logic [7:0] head_byte(input logic [HEAD_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0: b = 8'h46;
            4'd1: b = 8'h4C;
            4'd2: b = 8'h56;
            4'd3: b = 8'h01;
            4'd4: b = 8'h05;
            4'd8: b = 8'h09;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/ftrt_front.sv =====
// Front part: configuration registers, FLV tag parser and transaction classifier.
module ftrt_front #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [ftrt_pkg::REG_W-1:0] cfg_data,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       first_byte,
    output logic                       op_valid,
    output ftrt_pkg::op_t              op
);

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_SEEK = 2'd1;
    localparam logic [1:0] MODE_PASS = 2'd2;
    localparam logic [1:0] MODE_LAST = 2'd3;

    localparam int CW = (OFFSET_BITS > ftrt_pkg::REG_W) ? OFFSET_BITS : ftrt_pkg::REG_W;
    localparam int SW = OFFSET_BITS + 2;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

    logic [ftrt_pkg::REG_W-1:0] start_reg;
    logic [ftrt_pkg::REG_W-1:0] end_reg;

    logic [1:0]             mode_reg, mode_next, cur_mode;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next, cur_pos;
    logic [OFFSET_BITS-1:0] nto_reg, nto_next, cur_nto;
    logic [OFFSET_BITS-1:0] cto_reg, cto_next, cur_cto;
    logic [3:0]             tbi_reg, tbi_next, cur_tbi;
    logic [23:0]            acc_reg, acc_next, cur_acc;

    logic [23:0]            hb_acc;
    logic                   hb_done;
    logic [3:0]             hb_tbi;
    logic [SW-1:0]          hb_sum;
    logic [OFFSET_BITS-1:0] hb_nto;
    logic                   at_max;
    logic                   ge_start;
    logic                   ge_end;
    logic                   ge_hdr;
    logic                   ge_nto;
    logic                   tag_start;
    logic [OFFSET_BITS:0]   pos_plus1;

    always_comb
    begin
        if (first_byte)
        begin
            cur_mode = MODE_HEADER;
            cur_pos = '0;
            cur_nto = OFFSET_BITS'(ftrt_pkg::FIRST_TAG_OFFSET);
            cur_cto = '0;
            cur_tbi = '0;
            cur_acc = '0;
        end
        else
        begin
            cur_mode = mode_reg;
            cur_pos = pos_reg;
            cur_nto = nto_reg;
            cur_cto = cto_reg;
            cur_tbi = tbi_reg;
            cur_acc = acc_reg;
        end
    end

    assign hb_acc = (cur_tbi >= 4'd1 && cur_tbi <= 4'd3) ? {cur_acc[15:0], data_byte} : cur_acc;
    assign hb_done = (cur_tbi >= 4'(ftrt_pkg::TAG_HDR_LAST));
    assign hb_tbi = hb_done ? 4'd0 : cur_tbi + 4'd1;
    assign hb_sum = SW'(cur_cto) + SW'(ftrt_pkg::TAG_OVERHEAD) + SW'(hb_acc);
    assign hb_nto = (hb_sum > SW'(OFF_MAX)) ? OFF_MAX : hb_sum[OFFSET_BITS-1:0];

    assign at_max = (cur_pos == OFF_MAX);
    assign ge_start = (CW'(cur_pos) >= CW'(start_reg));
    assign ge_end = (CW'(cur_pos) >= CW'(end_reg));
    assign ge_hdr = (cur_pos >= OFFSET_BITS'(ftrt_pkg::FILE_HDR_LAST));
    assign ge_nto = (cur_pos >= cur_nto);
    assign pos_plus1 = {1'b0, cur_pos} + {{OFFSET_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        mode_next = cur_mode;
        pos_next = at_max ? cur_pos : pos_plus1[OFFSET_BITS-1:0];
        nto_next = cur_nto;
        cto_next = cur_cto;
        tbi_next = cur_tbi;
        acc_next = cur_acc;
        tag_start = 1'b0;
        op_valid = 1'b0;
        op.data = data_byte;
        op.head = 1'b0;
        op.stream_end = 1'b0;
        if (start_reg == '0)
        begin
            op_valid = 1'b1;
        end
        else
        begin
            case (cur_mode)
                MODE_HEADER:
                begin
                    if (ge_hdr)
                    begin
                        mode_next = MODE_SEEK;
                        nto_next = OFFSET_BITS'(ftrt_pkg::FIRST_TAG_OFFSET);
                        tbi_next = '0;
                    end
                end
                MODE_LAST:
                begin
                    if (cur_tbi != 4'd0)
                    begin
                        acc_next = hb_acc;
                        tbi_next = hb_tbi;
                        if (hb_done)
                        begin
                            nto_next = hb_nto;
                        end
                        op_valid = 1'b1;
                    end
                    else if (!ge_nto)
                    begin
                        op_valid = 1'b1;
                    end
                    op.stream_end = (tbi_next == 4'd0) && (pos_plus1 == {1'b0, nto_next});
                end
                default:
                begin
                    if (cur_tbi != 4'd0)
                    begin
                        acc_next = hb_acc;
                        tbi_next = hb_tbi;
                        if (hb_done)
                        begin
                            nto_next = hb_nto;
                        end
                    end
                    else
                    begin
                        tag_start = (cur_pos == cur_nto) && !at_max;
                        if (tag_start)
                        begin
                            cto_next = cur_pos;
                            acc_next = '0;
                            tbi_next = 4'd1;
                        end
                    end
                    if (cur_mode == MODE_SEEK)
                    begin
                        if (tag_start && ge_start)
                        begin
                            op_valid = 1'b1;
                            op.head = 1'b1;
                            mode_next = MODE_PASS;
                        end
                    end
                    else
                    begin
                        if (tag_start && (end_reg != '0) && ge_end)
                        begin
                            mode_next = MODE_LAST;
                        end
                        op_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == ftrt_pkg::CFG_START)
            begin
                start_reg <= cfg_data;
            end
            else
            begin
                end_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HEADER;
            pos_reg <= '0;
            nto_reg <= OFFSET_BITS'(ftrt_pkg::FIRST_TAG_OFFSET);
            cto_reg <= '0;
            tbi_reg <= '0;
            acc_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pos_reg <= pos_next;
            nto_reg <= nto_next;
            cto_reg <= cto_next;
            tbi_reg <= tbi_next;
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== design/ftrt_queue.sv =====
// Short queue of classified transactions between the parser and the emitter.
module ftrt_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  ftrt_pkg::op_t               wr_op,
    input  logic                        rd_en,
    output ftrt_pkg::op_t               rd_op,
    output logic                        full,
    output logic                        empty,
    output logic [ftrt_pkg::QCNT_W-1:0] level
);

    ftrt_pkg::op_t                 slot_reg [ftrt_pkg::QUEUE_DEPTH];
    logic [ftrt_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ftrt_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ftrt_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full = (count_reg == ftrt_pkg::QCNT_W'(ftrt_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign level = count_reg;
    assign rd_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/ftrt_back.sv =====
// Back part: expands queued transactions into output bytes, inserting the FLV header.
module ftrt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  ftrt_pkg::op_t q_op,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          stream_end,
    output logic          inserting
);

    logic                              valid_reg;
    logic [7:0]                        byte_reg;
    logic                              last_reg;
    logic                              end_reg;
    logic [ftrt_pkg::HEAD_IDX_W-1:0]   hidx_reg;
    logic                              load;
    logic                              head_done;

    assign load = (!valid_reg || pop) && !q_empty;
    assign head_done = (hidx_reg == ftrt_pkg::HEAD_IDX_W'(ftrt_pkg::HEAD_LEN));
    assign q_pop = load && (!q_op.head || head_done);

    assign empty = !valid_reg;
    assign out_byte = byte_reg;
    assign run_last = last_reg;
    assign stream_end = end_reg;
    assign inserting = (hidx_reg != '0);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (q_op.head && !head_done)
            begin
                byte_reg <= ftrt_pkg::head_byte(hidx_reg);
                last_reg <= 1'b0;
                end_reg <= 1'b0;
            end
            else
            begin
                byte_reg <= q_op.data;
                last_reg <= 1'b1;
                end_reg <= q_op.stream_end;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hidx_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                if (q_op.head && !head_done)
                begin
                    hidx_reg <= hidx_reg + 1'b1;
                end
                else
                begin
                    hidx_reg <= '0;
                end
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/flv_tag_range_trimmer.sv =====
// Top level of the FLV tag range trimmer: parser, transaction queue and byte emitter.
// A kept byte passes through a queue slot and the output register to the result ports.
// Throughput: one input byte per cycle unless the queue is full; while the 13 inserted
// header bytes go out, the head entry waits and the four-entry queue fills, stalling input.
// Reset: both offset registers clear to zero (trimming off), the parser returns to the
// file header phase, and the queue and output register are empty.
module flv_tag_range_trimmer #(
    parameter int OFFSET_BITS = 40
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic                       cfg_index,
    input  logic [ftrt_pkg::REG_W-1:0] cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 data_byte,
    input  logic                       first_byte,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 out_byte,
    output logic                       run_last,
    output logic                       stream_end
);

    logic                          accept;
    logic                          op_valid;
    ftrt_pkg::op_t                 front_op;
    ftrt_pkg::op_t                 head_op;
    logic                          q_full;
    logic                          q_empty;
    logic                          q_pop;
    logic [ftrt_pkg::QCNT_W-1:0]   q_level;
    logic                          inserting;

    assign full = q_full;
    assign accept = push && !q_full;

    ftrt_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .op_valid   (op_valid),
        .op         (front_op)
    );

    ftrt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && op_valid),
        .wr_op  (front_op),
        .rd_en  (q_pop),
        .rd_op  (head_op),
        .full   (q_full),
        .empty  (q_empty),
        .level  (q_level)
    );

    ftrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_op       (head_op),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end),
        .inserting  (inserting)
    );

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= ftrt_pkg::QCNT_W'(ftrt_pkg::QUEUE_DEPTH))
        else $error("Transaction queue level exceeds its depth.");

    a_insert_shape: assert property (@(posedge clk) disable iff (!rst_n)
        inserting |-> (!empty && !run_last))
        else $error("Inserted header byte is missing or marked as last.");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && stream_end) |-> run_last)
        else $error("Stream end flagged on a byte that is not the last of its transaction.");

endmodule

// ===== test/flv_tag_range_trimmer_test.sv =====
// Self-checking testbench for the FLV tag range trimmer: directed table, then random streams.
module flv_tag_range_trimmer_test;

    localparam int REG_W = ftrt_pkg::REG_W;
    localparam int HEAD_LEN = ftrt_pkg::HEAD_LEN;
    localparam int ITEMS = 310;
    localparam int LIMIT_CYCLES = 300000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [REG_W-1:0] POS_MAX = '1;
    localparam logic [8*HEAD_LEN-1:0] FLV_SIG = 104'h464C5601050000000900000000;

    typedef enum logic [1:0] {
        SCAN_HEADER,
        SCAN_SEEK,
        SCAN_PASS,
        SCAN_LAST_TAG
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       stream_end;
    } trim_byte_t;

    typedef struct packed {
        logic [7:0] value;
        logic       first;
    } in_byte_t;

    typedef struct packed {
        logic             is_reg;
        logic             reg_idx;
        logic [REG_W-1:0] reg_val;
        logic [7:0]       value;
        logic             first;
        logic             pass_through;
    } plan_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write = 1'b0;
    logic             cfg_index = ftrt_pkg::CFG_START;
    logic [REG_W-1:0] cfg_data = '0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       data_byte = '0;
    logic             first_byte = 1'b0;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       out_byte;
    logic             run_last;
    logic             stream_end;

    logic [REG_W-1:0] trim_start;
    logic [REG_W-1:0] trim_end;
    scan_mode_t       scan_mode;
    logic [REG_W-1:0] scan_pos;
    logic [REG_W-1:0] next_tag_at;
    logic [REG_W-1:0] tag_at;
    logic [3:0]       hdr_idx;
    logic [23:0]      size_acc;

    trim_byte_t step_out[$];
    trim_byte_t trimmed_q[$];
    in_byte_t   stream_q[$];
    plan_row_t  plan_q[$];
    int         tag_offs[$];

    int errors = 0;
    int cycles = 0;
    int send_gap_pct = 0;
    int pop_stall_pct = 0;
    int kept_items = 0;
    int bytes_sent = 0;
    int streams = 0;
    int results_checked = 0;
    int headers_inserted = 0;
    int end_marks = 0;

    flv_tag_range_trimmer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_parser();
        scan_mode = SCAN_HEADER;
        scan_pos = '0;
        next_tag_at = REG_W'(ftrt_pkg::FIRST_TAG_OFFSET);
        tag_at = '0;
        hdr_idx = '0;
        size_acc = '0;
    endfunction

    function automatic void take_header_byte(input logic [7:0] v);
        logic [REG_W:0] sum;
        if (hdr_idx >= 1 && hdr_idx <= 3)
        begin
            size_acc = {size_acc[15:0], v};
        end
        if (hdr_idx >= ftrt_pkg::TAG_HDR_LAST)
        begin
            sum = {1'b0, tag_at} + (REG_W+1)'(ftrt_pkg::TAG_OVERHEAD) + (REG_W+1)'(size_acc);
            next_tag_at = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[REG_W-1:0];
            hdr_idx = '0;
        end
        else
        begin
            hdr_idx = hdr_idx + 1'b1;
        end
    endfunction

    function automatic void trim_step(input logic [7:0] v, input logic f);
        logic [REG_W-1:0] pos;
        logic             tag_start;
        step_out.delete();
        if (f)
        begin
            clear_parser();
        end
        pos = scan_pos;
        if (pos < POS_MAX)
        begin
            scan_pos = pos + 1'b1;
        end
        if (trim_start == '0)
        begin
            step_out.push_back({v, 1'b1, 1'b0});
        end
        else if (scan_mode == SCAN_HEADER)
        begin
            if (pos >= ftrt_pkg::FILE_HDR_LAST)
            begin
                scan_mode = SCAN_SEEK;
                next_tag_at = REG_W'(ftrt_pkg::FIRST_TAG_OFFSET);
                hdr_idx = '0;
            end
        end
        else if (scan_mode == SCAN_LAST_TAG)
        begin
            if (hdr_idx != 0 || pos < next_tag_at)
            begin
                if (hdr_idx != 0)
                begin
                    take_header_byte(v);
                end
                step_out.push_back({v, 1'b1,
                    (hdr_idx == 0 && {1'b0, pos} + 41'd1 == {1'b0, next_tag_at})});
            end
        end
        else
        begin
            tag_start = 1'b0;
            if (hdr_idx != 0)
            begin
                take_header_byte(v);
            end
            else if (pos == next_tag_at && pos != POS_MAX)
            begin
                tag_start = 1'b1;
                tag_at = pos;
                size_acc = '0;
                hdr_idx = 4'd1;
            end
            if (scan_mode == SCAN_SEEK)
            begin
                if (tag_start && pos >= trim_start)
                begin
                    for (int i = 0; i < HEAD_LEN; i++)
                    begin
                        step_out.push_back({FLV_SIG[8*(HEAD_LEN-1-i) +: 8], 2'b00});
                    end
                    scan_mode = SCAN_PASS;
                    step_out.push_back({v, 1'b1, 1'b0});
                end
            end
            else
            begin
                if (tag_start && trim_end != '0 && pos >= trim_end)
                begin
                    scan_mode = SCAN_LAST_TAG;
                end
                step_out.push_back({v, 1'b1, 1'b0});
            end
        end
    endfunction

    task automatic settle();
        push <= 1'b0;
        while (trimmed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(input logic idx, input logic [REG_W-1:0] val);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == ftrt_pkg::CFG_START)
        begin
            trim_start = val;
        end
        else
        begin
            trim_end = val;
        end
        cfg_write <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] v, input logic f, input logic pass_through);
        while ($urandom_range(99) < send_gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= v;
        first_byte <= f;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        trim_step(v, f);
        bytes_sent++;
        if (step_out.size() != 0)
        begin
            kept_items++;
        end
        if (step_out.size() == HEAD_LEN + 1)
        begin
            headers_inserted++;
        end
        if (pass_through)
        begin
            trimmed_q.push_back({v, 1'b1, 1'b0});
        end
        else
        begin
            foreach (step_out[i])
            begin
                trimmed_q.push_back(step_out[i]);
                if (step_out[i].stream_end)
                begin
                    end_marks++;
                end
            end
        end
    endtask

    function automatic void plan_byte(input logic [7:0] v, input logic f,
                                      input logic pass_through);
        plan_q.push_back({1'b0, ftrt_pkg::CFG_START, {REG_W{1'b0}}, v, f, pass_through});
    endfunction

    function automatic void plan_reg(input logic idx, input logic [REG_W-1:0] val);
        plan_q.push_back({1'b1, idx, val, 8'h00, 1'b0, 1'b0});
    endfunction

    function automatic logic [REG_W-1:0] pick_offset(input int zero_weight);
        int r;
        r = $urandom_range(0, 9);
        if (r < zero_weight)
        begin
            return '0;
        end
        if (r < 7 && tag_offs.size() != 0)
        begin
            return REG_W'(tag_offs[$urandom_range(0, tag_offs.size() - 1)]);
        end
        if (r == 7 && tag_offs.size() != 0)
        begin
            return REG_W'(tag_offs[$urandom_range(0, tag_offs.size() - 1)]
                          + $urandom_range(1, 3));
        end
        if (r == 9)
        begin
            return POS_MAX;
        end
        return REG_W'($urandom_range(1, 200));
    endfunction

    // Mostly well-formed streams with random content; the rest is noise, streams that
    // continue without a restart mark, ones with a random last tag size, and cut-off streams.
    task automatic build_stream();
        int          variant;
        int          ntags;
        int          size;
        int          data_len;
        logic [7:0]  v;
        stream_q.delete();
        tag_offs.delete();
        variant = $urandom_range(0, 9);
        if (variant == 0)
        begin
            repeat ($urandom_range(5, 40))
            begin
                stream_q.push_back({8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0});
            end
        end
        else
        begin
            for (int i = 0; i < HEAD_LEN; i++)
            begin
                v = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : FLV_SIG[8*(HEAD_LEN-1-i) +: 8];
                stream_q.push_back({v, i == 0 && variant != 1});
            end
            ntags = $urandom_range(1, 5);
            for (int t = 0; t < ntags; t++)
            begin
                tag_offs.push_back(stream_q.size());
                size = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                data_len = size;
                if (variant == 2 && t == ntags - 1)
                begin
                    size = $urandom_range(0, 24'hFFFFFF);
                    data_len = $urandom_range(0, 20);
                end
                stream_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                stream_q.push_back({8'(size >> 16), 1'b0});
                stream_q.push_back({8'(size >> 8), 1'b0});
                stream_q.push_back({8'(size), 1'b0});
                repeat (7 + data_len + 4)
                begin
                    stream_q.push_back({8'($urandom_range(0, 255)), 1'b0});
                end
            end
            if (variant == 3)
            begin
                stream_q = stream_q[0:$urandom_range(0, stream_q.size() - 2)];
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        trim_byte_t want;
        if (rst_n && pop && !empty)
        begin
            results_checked++;
            if (trimmed_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output, expected nothing, actual %02h/%0b/%0b",
                         $time, out_byte, run_last, stream_end);
            end
            else
            begin
                want = trimmed_q.pop_front();
                if (out_byte !== want.value)
                begin
                    errors++;
                    $display("%0t: out_byte expected %02h, actual %02h",
                             $time, want.value, out_byte);
                end
                if (run_last !== want.run_last)
                begin
                    errors++;
                    $display("%0t: run_last expected %0b, actual %0b",
                             $time, want.run_last, run_last);
                end
                if (stream_end !== want.stream_end)
                begin
                    errors++;
                    $display("%0t: stream_end expected %0b, actual %0b",
                             $time, want.stream_end, stream_end);
                end
            end
        end
        pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: no progress after %0d cycles", $time, cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        trim_start = '0;
        trim_end = '0;
        clear_parser();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With trimming off every byte comes straight back as one transaction; then trimmed.
        plan_byte(8'h00, 1'b1, 1'b1);
        plan_byte(8'hFF, 1'b0, 1'b1);
        plan_byte(8'h5A, 1'b0, 1'b1);
        plan_reg(ftrt_pkg::CFG_END, POS_MAX);
        plan_byte(8'h80, 1'b0, 1'b1);
        plan_reg(ftrt_pkg::CFG_START, POS_MAX);
        plan_byte(8'h46, 1'b1, 1'b0);
        plan_byte(8'hA3, 1'b0, 1'b0);
        plan_reg(ftrt_pkg::CFG_END, '0);
        plan_reg(ftrt_pkg::CFG_START, REG_W'(ftrt_pkg::FIRST_TAG_OFFSET));
        for (int i = 0; i < HEAD_LEN; i++)
        begin
            plan_byte(FLV_SIG[8*(HEAD_LEN-1-i) +: 8], i == 0, 1'b0);
        end
        plan_byte(8'h09, 1'b0, 1'b0);
        plan_byte(8'h00, 1'b0, 1'b0);
        plan_byte(8'h00, 1'b0, 1'b0);
        plan_byte(8'h01, 1'b0, 1'b0);

        foreach (plan_q[i])
        begin
            if (plan_q[i].is_reg)
            begin
                write_offset(plan_q[i].reg_idx, plan_q[i].reg_val);
            end
            else
            begin
                send_byte(plan_q[i].value, plan_q[i].first, plan_q[i].pass_through);
            end
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_gap_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_gap_pct = 69; pop_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  pop_stall_pct = 69; end
                default: begin send_gap_pct = 20; pop_stall_pct = 20; end
            endcase
            while (bytes_sent < ITEMS * (phase + 1) / 4)
            begin
                build_stream();
                if (streams == 0 || $urandom_range(0, 1) == 0)
                begin
                    write_offset(ftrt_pkg::CFG_START, pick_offset(2));
                    write_offset(ftrt_pkg::CFG_END, pick_offset(4));
                end
                foreach (stream_q[i])
                begin
                    if (bytes_sent >= ITEMS * (phase + 1) / 4)
                    begin
                        break;
                    end
                    send_byte(stream_q[i].value, stream_q[i].first, 1'b0);
                end
                streams++;
            end
        end

        push <= 1'b0;
        while (trimmed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d streams; %0d bytes produced output.",
                 bytes_sent, streams, kept_items);
        $display("Checked %0d output bytes, %0d inserted headers, %0d end-tag cuts.",
                 results_checked, headers_inserted, end_marks);
        if (errors == 0 && trimmed_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ftrt_pkg.sv
design/ftrt_front.sv
design/ftrt_queue.sv
design/ftrt_back.sv
design/flv_tag_range_trimmer.sv
test/flv_tag_range_trimmer_test.sv
